[hdl/scpt_pkg.sv]
// Package for the canonical position table: request, response and
// controller/datapath interface types, state enum and the board symmetry map.
// No dependencies.
package scpt_pkg;

    localparam int BOARD_DIM = 8;
    localparam int BOARD_BITS = BOARD_DIM * BOARD_DIM;
    localparam int KEY_BITS = 2 * BOARD_BITS;
    localparam int OUT_PAY_BITS = 32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SET = 1'b1;
    localparam logic SIDE_WHITE = 1'b1;
    localparam logic [2:0] SYM_FIRST = 3'd0;
    localparam logic [2:0] SYM_LAST = 3'd7;

    typedef logic [BOARD_BITS-1:0] t_board;
    typedef logic [KEY_BITS-1:0] t_key;

    typedef struct packed {
        logic        cmd;
        t_board      black_disks;
        t_board      white_disks;
        logic        to_move;
        logic [31:0] payload_in;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic [OUT_PAY_BITS-1:0] payload_out;
        logic                    status;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SYM,
        ST_SRCH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       sym_step;
        logic       sym_first;
        logic [2:0] sym_sel;
        logic       rd_en;
        logic       finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic more;
        logic hit;
        logic miss;
    } t_dp_sts;

    // value at (x,y) of the mapped board is the source square (sx,sy)
    function automatic t_board sym_map(input t_board bb, input logic [2:0] t);
        t_board r;
        int sx;
        int sy;
        r = '0;
        for (int y = 0; y < BOARD_DIM; y++) begin
            for (int x = 0; x < BOARD_DIM; x++) begin
                case (t)
                    3'd0: begin
                        sx = x;
                        sy = y;
                    end
                    3'd1: begin
                        sx = BOARD_DIM - 1 - x;
                        sy = y;
                    end
                    3'd2: begin
                        sx = x;
                        sy = BOARD_DIM - 1 - y;
                    end
                    3'd3: begin
                        sx = BOARD_DIM - 1 - x;
                        sy = BOARD_DIM - 1 - y;
                    end
                    3'd4: begin
                        sx = y;
                        sy = x;
                    end
                    3'd5: begin
                        sx = BOARD_DIM - 1 - y;
                        sy = x;
                    end
                    3'd6: begin
                        sx = y;
                        sy = BOARD_DIM - 1 - x;
                    end
                    default: begin
                        sx = BOARD_DIM - 1 - y;
                        sy = BOARD_DIM - 1 - x;
                    end
                endcase
                r[y*BOARD_DIM+x] = bb[sy*BOARD_DIM+sx];
            end
        end
        return r;
    endfunction

endpackage

[hdl/scpt_ctrl.sv]
// Controller for the canonical position table: sequences capture, the eight
// symmetry steps, the linear search and the finishing write/response.
// Depends on scpt_pkg.
module scpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  scpt_pkg::t_dp_sts i_sts,
    output scpt_pkg::t_dp_cmd o_cmd,
    output logic             busy
);
    import scpt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_sym;
    logic [2:0] n_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sym   <= SYM_FIRST;
        end else begin
            r_state <= n_state;
            r_sym   <= n_sym;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sym   = r_sym;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_sym         = SYM_FIRST;
                    n_state       = ST_SYM;
                end
            end
            ST_SYM: begin
                o_cmd.sym_step  = 1'b1;
                o_cmd.sym_sel   = r_sym;
                o_cmd.sym_first = (r_sym == SYM_FIRST);
                n_sym           = r_sym + 3'd1;
                if (r_sym == SYM_LAST) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                o_cmd.rd_en = i_sts.more && !i_sts.hit;
                if (i_sts.hit || i_sts.miss) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

[hdl/scpt_dp.sv]
// Datapath for the canonical position table: request register, canonical key
// reduction, key/payload memories, search pipeline and response register.
// Depends on scpt_pkg.
module scpt_dp #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scpt_pkg::t_req    i_req,
    input  scpt_pkg::t_dp_cmd i_cmd,
    output scpt_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output scpt_pkg::t_rsp    o_rsp
);
    import scpt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_req                    r_req;
    t_key                    r_best;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_rd_idx;
    logic                    r_cmp_vld;
    logic [IW-1:0]           r_cmp_idx;
    t_key                    r_key_q;
    logic [PAYLOAD_BITS-1:0] r_pay_q;
    t_key                    r_key_mem [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] r_pay_mem [TABLE_DEPTH];
    logic                    r_valid;
    t_rsp                    r_rsp;

    t_board                  w_own;
    t_board                  w_opp;
    t_key                    w_cur;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_set;
    logic                    w_key_we;
    logic                    w_pay_we;
    logic [IW-1:0]           w_wr_addr;
    logic [PAYLOAD_BITS-1:0] w_pay_wr;
    t_rsp                    n_rsp;

    assign w_own = (r_req.to_move == SIDE_WHITE) ? r_req.white_disks : r_req.black_disks;
    assign w_opp = (r_req.to_move == SIDE_WHITE) ? r_req.black_disks : r_req.white_disks;
    assign w_cur = {sym_map(w_opp, i_cmd.sym_sel), sym_map(w_own, i_cmd.sym_sel)};

    assign w_hit     = r_cmp_vld && (r_key_q == r_best);
    assign w_full    = (r_count == DEPTH_C);
    assign w_set     = (r_req.cmd == CMD_SET);
    assign w_key_we  = i_cmd.finish && w_set && !w_hit && !w_full;
    assign w_pay_we  = i_cmd.finish && w_set && (w_hit || !w_full);
    assign w_wr_addr = w_hit ? r_cmp_idx : r_count[IW-1:0];
    assign w_pay_wr  = PAYLOAD_BITS'(r_req.payload_in);

    assign o_sts.more = (r_rd_idx < r_count);
    assign o_sts.hit  = w_hit;
    assign o_sts.miss = !r_cmp_vld && !o_sts.more;

    always_comb begin
        n_rsp.found       = w_hit;
        n_rsp.payload_out = (!w_set && w_hit) ? OUT_PAY_BITS'(r_pay_q) : '0;
        n_rsp.status      = w_set && !w_hit && w_full;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.sym_step && (i_cmd.sym_first || (w_cur < r_best))) begin
            r_best <= w_cur;
        end
        if (i_cmd.rd_en) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.capture) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= i_cmd.rd_en;
                if (i_cmd.rd_en) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end
            if (w_key_we) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_wr_addr] <= r_best;
        end
        if (i_cmd.rd_en) begin
            r_key_q <= r_key_mem[r_rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_pay_mem[w_wr_addr] <= w_pay_wr;
        end
        if (i_cmd.rd_en) begin
            r_pay_q <= r_pay_mem[r_rd_idx[IW-1:0]];
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rsp.status) |-> (!r_rsp.found && (r_rsp.payload_out == '0)))
        else $error("table-full status with a hit or payload");

    a_pay_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_rsp.payload_out != '0)) |-> r_rsp.found)
        else $error("payload returned without a hit");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_rd_idx < r_count))
        else $error("search read beyond stored entries");

endmodule

[hdl/symmetry_canonical_position_table.sv]
// Top level of the canonical position table: controller plus datapath.
// Depends on scpt_pkg, scpt_ctrl and scpt_dp.
//
// A request is taken when start is high and busy is low. The board is reduced
// to its canonical key over the eight square symmetries, one symmetry per
// cycle, then the stored keys are searched in insertion order, one memory
// read per cycle, until a hit or until all stored entries have been read.
// o_valid pulses for one cycle right after busy falls, and the result cannot
// be held off by the receiver. A set that misses appends a new entry while
// room remains; the table starts empty after reset and needs no clearing pass.
module symmetry_canonical_position_table #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  scpt_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output scpt_pkg::t_rsp o_rsp
);
    import scpt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    scpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    scpt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

[tb/sv/symmetry_canonical_position_table_tb.sv]
// Self-checking testbench for symmetry_canonical_position_table: drives lookup
// and set requests, predicts each response with its own canonical-key model.
// Depends on scpt_pkg and the RTL of the block.
module symmetry_canonical_position_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scpt_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int RANDOM_ITEMS = 360;
    localparam logic SIDE_BLACK = ~SIDE_WHITE;

    typedef struct packed {
        t_board black;
        t_board white;
        logic   side;
    } t_board_pos;

    class t_table_sb;
        t_key        stored_key[TABLE_ENTRIES];
        logic [31:0] stored_payload[TABLE_ENTRIES];
        int          entry_count;
        t_rsp        pending_rsp[$];
        int          error_count;

        function new();
            entry_count = 0;
            error_count = 0;
        endfunction

        // symmetry code: bit 2 swaps x and y, bit 0 mirrors x, bit 1 mirrors y
        function t_board map_board(input t_board bb, input logic [2:0] sym);
            t_board     r;
            logic [5:0] sq;
            logic [2:0] a;
            logic [2:0] b;
            r = '0;
            for (int i = 0; i < BOARD_BITS; i++) begin
                sq = 6'(i);
                a = sym[2] ? sq[5:3] : sq[2:0];
                b = sym[2] ? sq[2:0] : sq[5:3];
                r[sq] = bb[{b ^ {3{sym[1]}}, a ^ {3{sym[0]}}}];
            end
            return r;
        endfunction

        function t_key canonical_key(input t_req r);
            t_board own;
            t_board opp;
            t_key   best;
            t_key   cand;
            own = (r.to_move == SIDE_WHITE) ? r.white_disks : r.black_disks;
            opp = (r.to_move == SIDE_WHITE) ? r.black_disks : r.white_disks;
            best = {opp, own};
            for (int t = 1; t < 8; t++) begin
                cand = {map_board(opp, t[2:0]), map_board(own, t[2:0])};
                if (cand < best) best = cand;
            end
            return best;
        endfunction

        function void apply_request(input t_req r);
            t_key key;
            t_rsp rsp;
            bit   hit;
            int   idx;
            key = canonical_key(r);
            hit = 0;
            idx = 0;
            for (int i = 0; i < entry_count; i++) begin
                if (stored_key[i] == key) begin
                    hit = 1;
                    idx = i;
                    break;
                end
            end
            rsp = '0;
            rsp.found = hit;
            if (r.cmd == CMD_LOOKUP) begin
                if (hit) rsp.payload_out = stored_payload[idx];
            end else if (hit) begin
                stored_payload[idx] = r.payload_in;
            end else if (entry_count < TABLE_ENTRIES) begin
                stored_key[entry_count] = key;
                stored_payload[entry_count] = r.payload_in;
                entry_count++;
            end else begin
                rsp.status = 1'b1;
            end
            pending_rsp.push_back(rsp);
        endfunction

        function void compare_response(input t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none actual %p", $time, got);
                error_count++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0h actual %0h", $time, want.found, got.found);
                error_count++;
            end
            if (got.payload_out !== want.payload_out) begin
                $display("%0t: payload_out expected %08h actual %08h",
                         $time, want.payload_out, got.payload_out);
                error_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0h actual %0h", $time, want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    t_table_sb  sb = new();
    t_board_pos known_pos[$];

    symmetry_canonical_position_table #(
        .TABLE_DEPTH (TABLE_ENTRIES),
        .PAYLOAD_BITS(32)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.compare_response(o_rsp);
            if (start && !busy) sb.apply_request(i_req);
        end
    end

    function automatic t_req make_req(input logic cmd, input t_board blk, input t_board wht,
                                      input logic side, input logic [31:0] pay);
        t_req r;
        r.cmd = cmd;
        r.black_disks = blk;
        r.white_disks = wht;
        r.to_move = side;
        r.payload_in = pay;
        return r;
    endfunction

    function automatic t_board rand_board();
        t_board a;
        t_board b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a;
            1: return a & b;
            2: return a | b;
            default: return t_board'(1) << $urandom_range(0, BOARD_BITS - 1);
        endcase
    endfunction

    task automatic issue(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        if (r.cmd == CMD_SET) known_pos.push_back({r.black_disks, r.white_disks, r.to_move});
    endtask

    task automatic issue_fresh(input logic cmd);
        t_board blk;
        t_board wht;
        blk = rand_board();
        wht = rand_board();
        if ($urandom_range(0, 1)) wht = wht & ~blk;
        issue(make_req(cmd, blk, wht, 1'($urandom_range(0, 1)), $urandom));
    endtask

    // a stored position seen through a random symmetry, colours optionally swapped
    task automatic issue_known(input logic cmd);
        t_board_pos p;
        logic [2:0] sym;
        t_board     blk;
        t_board     wht;
        p = known_pos[$urandom_range(0, known_pos.size() - 1)];
        sym = 3'($urandom_range(0, 7));
        blk = sb.map_board(p.black, sym);
        wht = sb.map_board(p.white, sym);
        if ($urandom_range(0, 1)) issue(make_req(cmd, wht, blk, ~p.side, $urandom));
        else issue(make_req(cmd, blk, wht, p.side, $urandom));
    endtask

    task automatic maybe_pause(input bit allowed);
        if (allowed && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1)) do @(posedge i_clk); while (busy);
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_board corner_blk;
        t_board corner_wht;
        t_board mixed;
        int     pick;
        corner_blk = t_board'(1);
        corner_wht = t_board'(1) << 9;
        mixed = {$urandom, $urandom};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(make_req(CMD_LOOKUP, '0, '0, SIDE_BLACK, 32'hFFFF_FFFF));
        maybe_pause(1);
        issue(make_req(CMD_SET, '0, '0, SIDE_BLACK, 32'hFFFF_FFFF));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, '0, '0, SIDE_WHITE, '0));
        maybe_pause(1);
        issue(make_req(CMD_SET, '1, '0, SIDE_BLACK, '0));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, '0, '1, SIDE_WHITE, 32'hFFFF_FFFF));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, '1, '0, SIDE_WHITE, '0));
        maybe_pause(1);
        issue(make_req(CMD_SET, '1, '1, SIDE_WHITE, 32'hA5A5_A5A5));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, '1, '1, SIDE_BLACK, '0));
        maybe_pause(1);
        issue(make_req(CMD_SET, corner_blk, corner_wht, SIDE_BLACK, 32'h1234_5678));
        for (int t = 1; t < 8; t++) begin
            maybe_pause(1);
            issue(make_req(CMD_LOOKUP, sb.map_board(corner_blk, t[2:0]),
                           sb.map_board(corner_wht, t[2:0]), SIDE_BLACK, '0));
        end
        issue(make_req(CMD_SET, sb.map_board(corner_blk, 3'd5), sb.map_board(corner_wht, 3'd5),
                       SIDE_BLACK, 32'h8765_4321));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, corner_wht, corner_blk, SIDE_WHITE, '0));
        maybe_pause(1);
        issue(make_req(CMD_SET, mixed, mixed, SIDE_WHITE, $urandom));
        maybe_pause(1);
        issue(make_req(CMD_LOOKUP, mixed, mixed, SIDE_BLACK, $urandom));
        maybe_pause(1);
        issue_fresh(CMD_LOOKUP);
        maybe_pause(1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) issue_fresh(CMD_SET);
            else if (pick < 75) issue_known(CMD_LOOKUP);
            else if (pick < 87) issue_known(CMD_SET);
            else issue_fresh(CMD_LOOKUP);
            maybe_pause((n % 64) < 44);
        end

        // closing requests back to back, no idling
        for (int n = 0; n < 16; n++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) issue_fresh(CMD_SET);
            else if (pick == 1) issue_known(CMD_SET);
            else if (pick == 2) issue_known(CMD_LOOKUP);
            else issue_fresh(CMD_LOOKUP);
        end
        start <= 1'b0;

        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 20) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(80_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

[symmetry_canonical_position_table.f]
hdl/scpt_pkg.sv
hdl/scpt_ctrl.sv
hdl/scpt_dp.sv
hdl/symmetry_canonical_position_table.sv
tb/sv/symmetry_canonical_position_table_tb.sv
